[src/cpad_pkg.sv]
// Shared constants and types for the command packet actuator driver.
`timescale 1ns / 1ps

package cpad_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [2:0] LAST_DATA_COUNT = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_STEP_INTERVAL = 3'd0;
  localparam logic [2:0] CFG_LINK_TIMEOUT  = 3'd1;
  localparam logic [2:0] CFG_CENTER_ANGLE  = 3'd2;
  localparam logic [2:0] CFG_LEFT_ANGLE    = 3'd3;
  localparam logic [2:0] CFG_RIGHT_ANGLE   = 3'd4;

  localparam logic [7:0]  STEP_INTERVAL_RST = 8'd3;
  localparam logic [15:0] LINK_TIMEOUT_RST  = 16'd500;
  localparam logic [7:0]  CENTER_ANGLE_RST  = 8'd96;
  localparam logic [7:0]  LEFT_ANGLE_RST    = 8'd65;
  localparam logic [7:0]  RIGHT_ANGLE_RST   = 8'd127;

  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;
  localparam logic [7:0]        ANGLE_MAX = 8'd180;

  // floor(x * 255 / 100) as (x * DUTY_RECIP) >> 22, exact for x up to 100
  localparam logic [23:0] DUTY_RECIP = 24'd10695720;
  // floor(x / 100) as (x * DIV100_RECIP) >> 22, exact for x up to 25500
  localparam logic [15:0] DIV100_RECIP = 16'd41944;
  localparam int          RECIP_SHIFT = 22;

  typedef struct packed {
    logic [7:0] fwd_duty;
    logic [7:0] rev_duty;
    logic [7:0] angle;
    logic [3:0] pan_coils;
    logic [3:0] tilt_coils;
    logic       accepted;
    logic       bad;
  } result_t;

endpackage

[src/command_packet_actuator_driver.sv]
// Each accepted word's result is registered, into the skid entry if the output is stalled.
// Throughput: one word per cycle while the skid entry is empty; each update is one logic pass.
// A two-entry output buffer lets input accept one more word while the output is stalled.
// Reset (synchronous, rst high) clears parser, time, stepper and drive state, sets the
// angle to 96 and loads the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module command_packet_actuator_driver
  import cpad_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  motor_fwd_duty,
  output logic [7:0]  motor_rev_duty,
  output logic [7:0]  servo_angle,
  output logic [3:0]  pan_coils,
  output logic [3:0]  tilt_coils,
  output logic        packet_accepted,
  output logic        checksum_error
);

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration
  logic [7:0]  step_interval_ms;
  logic [15:0] link_timeout_ms;
  logic [7:0]  center_angle;
  logic [7:0]  left_angle;
  logic [7:0]  right_angle;

  // state
  logic             rx_active, rx_active_next;
  logic [2:0]       rx_count, rx_count_next;
  logic [7:0]       field_bytes [4];
  logic [7:0]       running_xor, running_xor_next;
  time_t            now_ms, now_ms_next;
  time_t            last_packet_ms, last_packet_ms_next;
  logic             packet_seen, packet_seen_next;
  logic signed [7:0] pan_direction, pan_direction_next;
  logic signed [7:0] tilt_direction, tilt_direction_next;
  logic [1:0]       pan_phase, pan_phase_next;
  logic [1:0]       tilt_phase, tilt_phase_next;
  time_t            pan_last_step_ms, pan_last_step_ms_next;
  time_t            tilt_last_step_ms, tilt_last_step_ms_next;
  logic [3:0]       pan_coil_reg, pan_coil_reg_next;
  logic [3:0]       tilt_coil_reg, tilt_coil_reg_next;
  logic [7:0]       fwd_duty_reg, fwd_duty_reg_next;
  logic [7:0]       rev_duty_reg, rev_duty_reg_next;
  logic [7:0]       angle_reg, angle_reg_next;

  // output buffer
  result_t main_res, skid_res, new_res;
  logic    skid_valid;
  logic    accept, pop;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  function automatic logic signed [7:0] clamp100(input logic signed [7:0] v);
    logic signed [7:0] r;
    r = v;
    if (v > SPEED_MAX) r = SPEED_MAX;
    if (v < SPEED_MIN) r = SPEED_MIN;
    return r;
  endfunction

  function automatic logic [6:0] mag7(input logic signed [7:0] v);
    logic [7:0] m;
    m = v[7] ? 8'(-v) : 8'(v);
    return m[6:0];
  endfunction

  function automatic logic [7:0] duty_of(input logic [6:0] mag);
    logic [30:0] p;
    p = 31'(mag) * 31'(DUTY_RECIP);
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'(DIV100_RECIP);
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  function automatic logic [7:0] saturate_angle(input logic signed [9:0] a);
    logic [7:0] r;
    if (a < 10'sd0) r = 8'd0;
    else if (a > $signed({2'b00, ANGLE_MAX})) r = ANGLE_MAX;
    else r = a[7:0];
    return r;
  endfunction

  // Steering angle from a raw steer byte, truncating the scaled offset toward zero
  function automatic logic [7:0] steer_angle(input logic signed [7:0] steer,
                                             input logic [7:0] c,
                                             input logic [7:0] l,
                                             input logic [7:0] r);
    logic signed [7:0] s;
    logic signed [9:0] diff;
    logic [8:0]        dmag9;
    logic [14:0]       prod;
    logic [7:0]        q;
    logic              neg;
    logic signed [9:0] a;
    s     = clamp100(steer);
    diff  = s[7] ? ($signed({2'b00, c}) - $signed({2'b00, l}))
                 : ($signed({2'b00, r}) - $signed({2'b00, c}));
    dmag9 = diff[9] ? 9'(-diff) : 9'(diff);
    prod  = 15'(mag7(s)) * 15'(dmag9[7:0]);
    q     = div100(prod);
    neg   = s[7] ^ diff[9];
    a     = neg ? ($signed({2'b00, c}) - $signed({2'b00, q}))
                : ($signed({2'b00, c}) + $signed({2'b00, q}));
    return saturate_angle(a);
  endfunction

  // per-word state update
  always_comb begin
    logic signed [7:0] s_drive;
    logic [7:0]        duty;
    time_t             elapsed;
    rx_active_next         = rx_active;
    rx_count_next          = rx_count;
    running_xor_next       = running_xor;
    now_ms_next            = now_ms;
    last_packet_ms_next    = last_packet_ms;
    packet_seen_next       = packet_seen;
    pan_direction_next     = pan_direction;
    tilt_direction_next    = tilt_direction;
    pan_phase_next         = pan_phase;
    tilt_phase_next        = tilt_phase;
    pan_last_step_ms_next  = pan_last_step_ms;
    tilt_last_step_ms_next = tilt_last_step_ms;
    pan_coil_reg_next      = pan_coil_reg;
    tilt_coil_reg_next     = tilt_coil_reg;
    fwd_duty_reg_next      = fwd_duty_reg;
    rev_duty_reg_next      = rev_duty_reg;
    angle_reg_next         = angle_reg;
    new_res.accepted       = 1'b0;
    new_res.bad            = 1'b0;
    s_drive                = clamp100($signed(field_bytes[0]));
    duty                   = duty_of(mag7(s_drive));
    elapsed                = '0;

    if (!op) begin
      if (!rx_active) begin
        if (rx_byte == START_BYTE) begin
          rx_active_next   = 1'b1;
          rx_count_next    = 3'd1;
          running_xor_next = START_BYTE;
        end
      end else if (rx_count < LAST_DATA_COUNT) begin
        running_xor_next = running_xor ^ rx_byte;
        rx_count_next    = rx_count + 3'd1;
      end else begin
        if (running_xor == rx_byte) begin
          fwd_duty_reg_next   = (s_drive > 8'sd0) ? duty : 8'd0;
          rev_duty_reg_next   = (s_drive < 8'sd0) ? duty : 8'd0;
          angle_reg_next      = steer_angle($signed(field_bytes[1]), center_angle,
                                            left_angle, right_angle);
          pan_direction_next  = $signed(field_bytes[2]);
          tilt_direction_next = $signed(field_bytes[3]);
          last_packet_ms_next = now_ms;
          packet_seen_next    = 1'b1;
          new_res.accepted    = 1'b1;
        end else begin
          new_res.bad = 1'b1;
        end
        rx_active_next = 1'b0;
        rx_count_next  = 3'd0;
      end
    end else begin
      now_ms_next = now_ms + time_t'(1);
      if (pan_direction != 8'sd0 &&
          (now_ms_next - pan_last_step_ms) >= time_t'(step_interval_ms)) begin
        pan_last_step_ms_next = now_ms_next;
        pan_phase_next        = pan_direction[7] ? pan_phase - 2'd1 : pan_phase + 2'd1;
        pan_coil_reg_next     = 4'b0001 << pan_phase_next;
      end
      if (tilt_direction != 8'sd0 &&
          (now_ms_next - tilt_last_step_ms) >= time_t'(step_interval_ms)) begin
        tilt_last_step_ms_next = now_ms_next;
        tilt_phase_next        = tilt_direction[7] ? tilt_phase - 2'd1 : tilt_phase + 2'd1;
        tilt_coil_reg_next     = 4'b0001 << tilt_phase_next;
      end
      elapsed = now_ms_next - last_packet_ms;
      // link lost: stop the drive, center the steering, hold the coils
      if (packet_seen && elapsed > time_t'(link_timeout_ms)) begin
        fwd_duty_reg_next   = 8'd0;
        rev_duty_reg_next   = 8'd0;
        angle_reg_next      = saturate_angle($signed({2'b00, center_angle}));
        pan_direction_next  = 8'sd0;
        tilt_direction_next = 8'sd0;
      end
    end

    new_res.fwd_duty   = fwd_duty_reg_next;
    new_res.rev_duty   = rev_duty_reg_next;
    new_res.angle      = angle_reg_next;
    new_res.pan_coils  = pan_coil_reg_next;
    new_res.tilt_coils = tilt_coil_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval_ms <= STEP_INTERVAL_RST;
      link_timeout_ms  <= LINK_TIMEOUT_RST;
      center_angle     <= CENTER_ANGLE_RST;
      left_angle       <= LEFT_ANGLE_RST;
      right_angle      <= RIGHT_ANGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_INTERVAL: step_interval_ms <= cfg_data[7:0];
        CFG_LINK_TIMEOUT:  link_timeout_ms  <= cfg_data;
        CFG_CENTER_ANGLE:  center_angle     <= cfg_data[7:0];
        CFG_LEFT_ANGLE:    left_angle       <= cfg_data[7:0];
        CFG_RIGHT_ANGLE:   right_angle      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_active         <= 1'b0;
      rx_count          <= 3'd0;
      running_xor       <= 8'd0;
      now_ms            <= '0;
      last_packet_ms    <= '0;
      packet_seen       <= 1'b0;
      pan_direction     <= 8'sd0;
      tilt_direction    <= 8'sd0;
      pan_phase         <= 2'd0;
      tilt_phase        <= 2'd0;
      pan_last_step_ms  <= '0;
      tilt_last_step_ms <= '0;
      pan_coil_reg      <= 4'd0;
      tilt_coil_reg     <= 4'd0;
      fwd_duty_reg      <= 8'd0;
      rev_duty_reg      <= 8'd0;
      angle_reg         <= CENTER_ANGLE_RST;
    end else if (accept) begin
      rx_active         <= rx_active_next;
      rx_count          <= rx_count_next;
      running_xor       <= running_xor_next;
      now_ms            <= now_ms_next;
      last_packet_ms    <= last_packet_ms_next;
      packet_seen       <= packet_seen_next;
      pan_direction     <= pan_direction_next;
      tilt_direction    <= tilt_direction_next;
      pan_phase         <= pan_phase_next;
      tilt_phase        <= tilt_phase_next;
      pan_last_step_ms  <= pan_last_step_ms_next;
      tilt_last_step_ms <= tilt_last_step_ms_next;
      pan_coil_reg      <= pan_coil_reg_next;
      tilt_coil_reg     <= tilt_coil_reg_next;
      fwd_duty_reg      <= fwd_duty_reg_next;
      rev_duty_reg      <= rev_duty_reg_next;
      angle_reg         <= angle_reg_next;
    end
  end

  // data bytes of the packet, no reset
  always_ff @(posedge clk) begin
    if (accept && !op && rx_active && rx_count < LAST_DATA_COUNT) begin
      field_bytes[2'(rx_count - 3'd1)] <= rx_byte;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_res <= skid_res;
    end else if (accept) begin
      if (out_valid && !out_ready) skid_res <= new_res;
      else main_res <= new_res;
    end
  end

  assign motor_fwd_duty  = main_res.fwd_duty;
  assign motor_rev_duty  = main_res.rev_duty;
  assign servo_angle     = main_res.angle;
  assign pan_coils       = main_res.pan_coils;
  assign tilt_coils      = main_res.tilt_coils;
  assign packet_accepted = main_res.accepted;
  assign checksum_error  = main_res.bad;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid entry held without output word");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("word accepted under stall not held in skid");

  a_coils_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pan_coil_reg) && $onehot0(tilt_coil_reg))
    else $error("coil pattern not one-hot");

  a_parser_count: assert property (@(posedge clk) disable iff (rst)
    (rx_active == (rx_count != 3'd0)) && (rx_count <= LAST_DATA_COUNT))
    else $error("parser count inconsistent with active flag");

  a_pulse_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(packet_accepted && checksum_error))
    else $error("accept and checksum error in one word");

endmodule

[test/command_packet_actuator_driver_tb.sv]
// Randomized testbench for the command packet actuator driver, checked against a local predictor.
`timescale 1ns / 1ps

module command_packet_actuator_driver_tb;
  import cpad_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  class actuator_scoreboard;
    logic [7:0]  step_interval;
    logic [15:0] link_timeout;
    logic [7:0]  center;
    logic [7:0]  left_lim;
    logic [7:0]  right_lim;

    bit                 in_packet;
    logic [2:0]         byte_count;
    logic [7:0]         data_bytes [4];
    logic [7:0]         check_acc;
    logic [31:0]        now_ms;
    logic [31:0]        last_good_ms;
    bit                 link_up;
    logic signed [7:0]  step_dir [2];
    logic [1:0]         coil_phase [2];
    logic [31:0]        last_step_ms [2];
    logic [3:0]         coil_drive [2];
    logic [7:0]         fwd_duty;
    logic [7:0]         rev_duty;
    logic [7:0]         angle;

    result_t pending_actuator_states [$];
    int errors;

    function new();
      step_interval = STEP_INTERVAL_RST;
      link_timeout = LINK_TIMEOUT_RST;
      center = CENTER_ANGLE_RST;
      left_lim = LEFT_ANGLE_RST;
      right_lim = RIGHT_ANGLE_RST;
      in_packet = 0;
      byte_count = '0;
      check_acc = '0;
      now_ms = '0;
      last_good_ms = '0;
      link_up = 0;
      for (int k = 0; k < 4; k++) data_bytes[k] = '0;
      for (int k = 0; k < 2; k++) begin
        step_dir[k] = '0;
        coil_phase[k] = '0;
        last_step_ms[k] = '0;
        coil_drive[k] = '0;
      end
      fwd_duty = '0;
      rev_duty = '0;
      angle = CENTER_ANGLE_RST;
      errors = 0;
    endfunction

    function void load_config(logic [7:0] interval, logic [15:0] timeout,
                              logic [7:0] c, logic [7:0] l, logic [7:0] r);
      step_interval = interval;
      link_timeout = timeout;
      center = c;
      left_lim = l;
      right_lim = r;
    endfunction

    function int limit_pct(int v);
      if (v > 100) return 100;
      if (v < -100) return -100;
      return v;
    endfunction

    function void set_drive(int speed);
      int s;
      int duty;
      s = limit_pct(speed);
      duty = ((s < 0) ? -s : s) * 255 / 100;
      fwd_duty = (s > 0) ? duty[7:0] : 8'd0;
      rev_duty = (s < 0) ? duty[7:0] : 8'd0;
    endfunction

    function void set_steer(int steer);
      int s;
      int c;
      int a;
      s = limit_pct(steer);
      c = int'(center);
      if (s >= 0) a = c + s * (int'(right_lim) - c) / 100;
      else a = c + s * (c - int'(left_lim)) / 100;
      if (a < 0) a = 0;
      if (a > 180) a = 180;
      angle = a[7:0];
    endfunction

    // Returns 0 for a byte the block ignores while hunting for the start byte.
    function bit note_word(logic o, logic [7:0] b);
      result_t r;
      bit accepted;
      bit bad;
      bit effective;
      accepted = 0;
      bad = 0;
      effective = 1;
      if (o == OP_BYTE) begin
        if (!in_packet) begin
          if (b == START_BYTE) begin
            in_packet = 1;
            byte_count = 3'd1;
            check_acc = START_BYTE;
          end else begin
            effective = 0;
          end
        end else if (byte_count < LAST_DATA_COUNT) begin
          data_bytes[byte_count - 3'd1] = b;
          check_acc = check_acc ^ b;
          byte_count = byte_count + 3'd1;
        end else begin
          if (check_acc == b) begin
            set_drive($signed(data_bytes[0]));
            set_steer($signed(data_bytes[1]));
            step_dir[0] = data_bytes[2];
            step_dir[1] = data_bytes[3];
            last_good_ms = now_ms;
            link_up = 1;
            accepted = 1;
          end else begin
            bad = 1;
          end
          in_packet = 0;
          byte_count = '0;
        end
      end else begin
        now_ms = now_ms + 32'd1;
        for (int k = 0; k < 2; k++) begin
          if (step_dir[k] != 0 && (now_ms - last_step_ms[k]) >= step_interval) begin
            last_step_ms[k] = now_ms;
            coil_phase[k] = (step_dir[k] > 0) ? coil_phase[k] + 2'd1 : coil_phase[k] + 2'd3;
            coil_drive[k] = 4'b0001 << coil_phase[k];
          end
        end
        // link loss: drop drive and steering, stop stepping, keep coil patterns
        if (link_up && (now_ms - last_good_ms) > link_timeout) begin
          set_drive(0);
          set_steer(0);
          step_dir[0] = '0;
          step_dir[1] = '0;
        end
      end
      r.fwd_duty = fwd_duty;
      r.rev_duty = rev_duty;
      r.angle = angle;
      r.pan_coils = coil_drive[0];
      r.tilt_coils = coil_drive[1];
      r.accepted = accepted;
      r.bad = bad;
      pending_actuator_states.push_back(r);
      return effective;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_actuator_states.size() == 0) begin
        $display("%0t result word with nothing pending", $time);
        errors++;
        return;
      end
      want = pending_actuator_states.pop_front();
      compare_field("motor_fwd_duty", want.fwd_duty, got.fwd_duty);
      compare_field("motor_rev_duty", want.rev_duty, got.rev_duty);
      compare_field("servo_angle", want.angle, got.angle);
      compare_field("pan_coils", want.pan_coils, got.pan_coils);
      compare_field("tilt_coils", want.tilt_coils, got.tilt_coils);
      compare_field("packet_accepted", want.accepted, got.accepted);
      compare_field("checksum_error", want.bad, got.bad);
    endfunction

    function int pending();
      return pending_actuator_states.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  motor_fwd_duty;
  logic [7:0]  motor_rev_duty;
  logic [7:0]  servo_angle;
  logic [3:0]  pan_coils;
  logic [3:0]  tilt_coils;
  logic        packet_accepted;
  logic        checksum_error;

  actuator_scoreboard sb;
  bit idle_on;
  bit hold_request;
  int effective_items;
  int cycle_count;

  command_packet_actuator_driver u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .motor_fwd_duty  (motor_fwd_duty),
    .motor_rev_duty  (motor_rev_duty),
    .servo_angle     (servo_angle),
    .pan_coils       (pan_coils),
    .tilt_coils      (tilt_coils),
    .packet_accepted (packet_accepted),
    .checksum_error  (checksum_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("command_packet_actuator_driver test failed");
      $finish;
    end
  end

  task automatic send_word(input logic o, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_word(o, b)) effective_items++;
  endtask

  // flip = 0 sends a good check byte, anything else corrupts it
  task automatic send_packet(input logic [7:0] d0, input logic [7:0] d1,
                             input logic [7:0] d2, input logic [7:0] d3,
                             input logic [7:0] flip);
    send_word(OP_BYTE, START_BYTE);
    send_word(OP_BYTE, d0);
    send_word(OP_BYTE, d1);
    send_word(OP_BYTE, d2);
    send_word(OP_BYTE, d3);
    send_word(OP_BYTE, START_BYTE ^ d0 ^ d1 ^ d2 ^ d3 ^ flip);
  endtask

  function automatic logic [7:0] pick_data();
    if ($urandom_range(0, 3) != 0) return 8'($urandom);
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'h64;
      4: return 8'h9C;
      5: return 8'h65;
      default: return 8'h9B;
    endcase
  endfunction

  task automatic send_sequence();
    int kind;
    int n;
    logic [7:0] d [4];
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 4; i++) d[i] = pick_data();
    if (kind < 45) begin
      send_packet(d[0], d[1], d[2], d[3], 8'h00);
    end else if (kind < 55) begin
      send_packet(d[0], d[1], d[2], d[3], 8'($urandom_range(1, 255)));
    end else if (kind < 62) begin
      // cut short: the next bytes get framed as data
      send_word(OP_BYTE, START_BYTE);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_word(OP_BYTE, d[i]);
    end else if (kind < 70) begin
      send_word(OP_BYTE, 8'($urandom));
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
      repeat (n) send_word(OP_TICK, 8'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    int start_count;
    start_count = effective_items;
    while (effective_items - start_count < target) send_sequence();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] interval, input logic [15:0] timeout,
                              input logic [7:0] c, input logic [7:0] l,
                              input logic [7:0] r);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STEP_INTERVAL;
    cfg_data <= {8'd0, interval};
    @(posedge clk);
    cfg_index <= CFG_LINK_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    cfg_index <= CFG_CENTER_ANGLE;
    cfg_data <= {8'd0, c};
    @(posedge clk);
    cfg_index <= CFG_LEFT_ANGLE;
    cfg_data <= {8'd0, l};
    @(posedge clk);
    cfg_index <= CFG_RIGHT_ANGLE;
    cfg_data <= {8'd0, r};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_config(interval, timeout, c, l, r);
  endtask

  initial begin : result_side
    int stall_cnt;
    result_t got;
    stall_cnt = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        got.fwd_duty = motor_fwd_duty;
        got.rev_duty = motor_rev_duty;
        got.angle = servo_angle;
        got.pan_coils = pan_coils;
        got.tilt_coils = tilt_coils;
        got.accepted = packet_accepted;
        got.bad = checksum_error;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 0;
        stall_cnt = HOLD_CYCLES;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    sb = new();
    idle_on = 1;
    hold_request = 0;
    effective_items = 0;
    cycle_count = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_STEP_INTERVAL;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_BYTE;
    rx_byte <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // noise while hunting, a tick before any packet
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'h00);
    // clamped drive and steer, stepping both ways
    send_packet(8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00);
    repeat (3) send_word(OP_TICK, 8'hFF);
    // start byte taken as data, then a bad check byte
    send_packet(8'h9C, 8'h64, 8'h00, START_BYTE, 8'h01);
    send_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    apply_config(8'd1, 16'd20, 8'd90, 8'd0, 8'd180);
    run_random(260);
    drain();

    apply_config(8'd255, 16'hFFFF, 8'd180, 8'd0, 8'd0);
    hold_request = 1;
    run_random(260);
    drain();

    apply_config(8'd0, 16'd1, 8'd0, 8'd180, 8'd90);
    run_random(260);
    drain();

    apply_config(8'($urandom_range(1, 8)), 16'($urandom_range(5, 60)),
                 8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                 8'($urandom_range(0, 180)));
    run_random(260);
    drain();

    apply_config(STEP_INTERVAL_RST, LINK_TIMEOUT_RST, CENTER_ANGLE_RST,
                 LEFT_ANGLE_RST, RIGHT_ANGLE_RST);
    idle_on = 0;
    run_random(220);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("command_packet_actuator_driver test passed");
    end else begin
      $display("command_packet_actuator_driver test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cpad_pkg.sv
src/command_packet_actuator_driver.sv
test/command_packet_actuator_driver_tb.sv
